### hw/rtl/dtr_pkg.sv
// shared constants, types and helpers for the depth tested triangle rasterizer
// no dependencies; used by the rasterizer top level

package dtr_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
    localparam int X_W           = $clog2(SCREEN_WIDTH + 1);

    // fixed point datapath widths
    localparam int QW      = 40;       // Q24.16 x and Q24.16 z accumulators
    localparam int PW      = QW - 16;  // integer part of a Q value
    localparam int DW      = 48;       // divider dividend width
    localparam int DEN_W   = 16;       // divider divisor width
    localparam int MUL_A_W = 18;
    localparam int MUL_W   = MUL_A_W + QW;
    localparam int DCNT_W  = $clog2(DW + 1);

    localparam logic signed [15:0] DEPTH_FAR = 16'sh8000;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_DRAW  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [15:0] z;
    } vtx_t;

    typedef vtx_t [2:0] tri_t;

    // three element sort by y
    function automatic tri_t sort3(input tri_t v);
        tri_t s;
        vtx_t t;
        s = v;
        if (s[1].y < s[0].y)
        begin
            t = s[0]; s[0] = s[1]; s[1] = t;
        end
        if (s[2].y < s[0].y)
        begin
            t = s[0]; s[0] = s[2]; s[2] = t;
        end
        if (s[2].y < s[1].y)
        begin
            t = s[1]; s[1] = s[2]; s[2] = t;
        end
        return s;
    endfunction

    function automatic logic signed [QW-1:0] q_of_x(input logic signed [11:0] x);
        logic signed [QW-1:0] w;
        w = QW'(x);
        return w <<< 16;
    endfunction

    function automatic logic signed [QW-1:0] q_of_z(input logic signed [15:0] z);
        logic signed [QW-1:0] w;
        w = QW'(z);
        return w <<< 16;
    endfunction

    // divide by 65536 truncating toward zero
    function automatic logic signed [PW-1:0] q_trunc(input logic signed [QW-1:0] v);
        logic signed [PW-1:0] t;
        t = v[QW-1:16];
        if (v[QW-1] && (v[15:0] != 16'd0))
        begin
            t = t + PW'(1);
        end
        return t;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        logic signed [15:0] r;
        if (v > PW'(32767))
        begin
            r = 16'sh7fff;
        end
        else if (v < -PW'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/depth_tested_triangle_rasterizer.sv
// Draw runs its divides on the shared divider: 2 for the middle split,
// 4 per edge pair of nonzero height and 1 per on-screen row whose span
// ends differ. One item at a time: the next item enters once the result
// is in the output register. Reset (rst_n low, async) clears control
// only; pixel memories are undefined until the first clear.
// uses dtr_pkg

module depth_tested_triangle_rasterizer
    import dtr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic signed [11:0]  ax,
    input  logic signed [11:0]  ay,
    input  logic signed [15:0]  az,
    input  logic signed [11:0]  bx,
    input  logic signed [11:0]  by_,
    input  logic signed [15:0]  bz,
    input  logic signed [11:0]  cx,
    input  logic signed [11:0]  cy,
    input  logic signed [15:0]  cz,
    input  logic [31:0]         fill_color,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         read_color,
    output logic signed [15:0]  read_depth,
    output logic [15:0]         written_count
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR, ST_RD, ST_RD_DATA, ST_SORT, ST_SETUP,
        ST_MIDX, ST_MIDX_DIV, ST_MIDZ, ST_MIDZ_DIV, ST_PART, ST_DIV,
        ST_ROW, ST_SPAN_MUL, ST_SPAN_INIT, ST_PX_RD, ST_PX_WR,
        ST_ROW_NEXT, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        DJ_MIDX, DJ_MIDZ, DJ_DX1, DJ_DZ1, DJ_DX2, DJ_DZ2, DJ_ZI
    } job_t;

    state_t state_reg;
    job_t   div_job_reg;

    cmd_t               cmd_reg;
    tri_t               v_reg;
    logic [31:0]        fill_reg;
    vtx_t               top_reg;
    logic signed [11:0] b1y_reg;
    logic               second_reg;

    logic signed [QW-1:0] mid_x_reg, mid_z_reg;
    logic signed [QW-1:0] b1x_reg, b1z_reg, b2x_reg, b2z_reg;
    logic signed [QW-1:0] dx1_reg, dz1_reg, dx2_reg, dz2_reg;
    logic signed [QW-1:0] rxa_reg, rza_reg, rxb_reg, rzb_reg;
    logic [11:0]          steps_reg, row_i_reg;
    logic                 dir_neg_reg;
    logic signed [12:0]   row_y_reg;

    logic signed [PW-1:0] sl_reg, sr_reg;
    logic signed [QW-1:0] szl_reg, zi_reg, zacc_reg;
    logic [X_W-1:0]       px_x_reg, px_hi_reg;
    logic signed [MUL_W-1:0] mul_reg;

    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [31:0]          res_color_reg;
    logic signed [15:0]   res_depth_reg;
    logic [15:0]          wcount_reg;

    logic                 out_valid_reg;
    logic [31:0]          read_color_reg;
    logic signed [15:0]   read_depth_reg;
    logic [15:0]          written_count_reg;

    // shared divider registers
    logic [DW-1:0]        div_num_reg, div_quo_reg;
    logic [DEN_W-1:0]     div_rem_reg, div_den_reg;
    logic                 div_neg_reg;
    logic [DCNT_W-1:0]    div_cnt_reg;

    // pixel memories
    logic [31:0]          color_mem [PIX_COUNT];
    logic signed [15:0]   depth_mem [PIX_COUNT];
    logic [31:0]          color_q_reg;
    logic signed [15:0]   depth_q_reg;

    tri_t                 srt;
    logic signed [12:0]   part_dy;
    logic [11:0]          part_steps;
    logic signed [QW-1:0] top_xq, top_zq;
    logic signed [PW-1:0] xa_i, xb_i, span_xl, span_xr, span_lo, span_hi;
    logic signed [QW-1:0] span_zl, span_zr;
    logic                 row_on;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [QW-1:0] mul_b;
    logic                 div_go;
    logic signed [DW-1:0] div_go_val;
    logic [DEN_W-1:0]     div_go_den;
    job_t                 div_go_job;
    logic [DEN_W:0]       div_shift;
    logic signed [DW-1:0] div_q;
    logic signed [15:0]   px_z;
    logic                 px_pass;
    logic [ADDR_W-1:0]    px_idx, rd_idx, mem_raddr, mem_waddr;
    logic                 mem_we;
    logic [31:0]          mem_wcolor;
    logic signed [15:0]   mem_wdepth;
    logic                 rd_on;
    logic                 out_free;

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign read_color    = read_color_reg;
    assign read_depth    = read_depth_reg;
    assign written_count = written_count_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    // sort, edge setup and span ends
    always_comb
    begin
        srt        = sort3(v_reg);
        top_xq     = q_of_x(top_reg.x);
        top_zq     = q_of_z(top_reg.z);
        part_dy    = 13'(top_reg.y) - 13'(b1y_reg);
        part_steps = part_dy[12] ? 12'(-part_dy) : 12'(part_dy);
        xa_i       = q_trunc(rxa_reg);
        xb_i       = q_trunc(rxb_reg);
        if (xb_i < xa_i)
        begin
            span_xl = xb_i; span_xr = xa_i; span_zl = rzb_reg; span_zr = rza_reg;
        end
        else
        begin
            span_xl = xa_i; span_xr = xb_i; span_zl = rza_reg; span_zr = rzb_reg;
        end
        row_on  = (row_y_reg >= 0) && (row_y_reg < SCREEN_HEIGHT);
        span_lo = (sl_reg < 0) ? PW'(0) : sl_reg;
        span_hi = (sr_reg > PW'(SCREEN_WIDTH - 1)) ? PW'(SCREEN_WIDTH - 1) : sr_reg;
        rd_on   = (v_reg[0].x >= 0) && (v_reg[0].x < SCREEN_WIDTH) &&
                  (v_reg[0].y >= 0) && (v_reg[0].y < SCREEN_HEIGHT);
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = MUL_A_W'(v_reg[1].y) - MUL_A_W'(v_reg[0].y);
        mul_b = QW'(v_reg[2].x) - QW'(v_reg[0].x);
        if (state_reg == ST_MIDZ)
        begin
            mul_b = QW'(v_reg[2].z) - QW'(v_reg[0].z);
        end
        else if (state_reg == ST_SPAN_MUL)
        begin
            mul_a = MUL_A_W'(span_lo - sl_reg);
            mul_b = zi_reg;
        end
    end

    // divider step and result
    always_comb
    begin
        div_shift = {div_rem_reg, div_num_reg[DW-1]};
        div_q     = div_neg_reg ? -$signed(div_quo_reg) : $signed(div_quo_reg);
    end

    // divider launch
    always_comb
    begin
        div_go     = 1'b0;
        div_go_val = '0;
        div_go_den = DEN_W'(steps_reg);
        div_go_job = DJ_DX1;
        unique case (state_reg)
            ST_MIDX_DIV, ST_MIDZ_DIV:
            begin
                div_go     = 1'b1;
                div_go_val = DW'(mul_reg) <<< 16;
                div_go_den = DEN_W'(13'(v_reg[2].y) - 13'(v_reg[0].y));
                div_go_job = (state_reg == ST_MIDX_DIV) ? DJ_MIDX : DJ_MIDZ;
            end
            ST_PART:
            begin
                div_go     = (part_steps != 12'd0);
                div_go_val = DW'(top_xq - b1x_reg);
                div_go_den = DEN_W'(part_steps);
                div_go_job = DJ_DX1;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    unique case (div_job_reg)
                        DJ_DX1:
                        begin
                            div_go = 1'b1; div_go_val = DW'(top_zq - b1z_reg);
                            div_go_job = DJ_DZ1;
                        end
                        DJ_DZ1:
                        begin
                            div_go = 1'b1; div_go_val = DW'(top_xq - b2x_reg);
                            div_go_job = DJ_DX2;
                        end
                        DJ_DX2:
                        begin
                            div_go = 1'b1; div_go_val = DW'(top_zq - b2z_reg);
                            div_go_job = DJ_DZ2;
                        end
                        default:
                        begin
                            div_go = 1'b0;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                div_go     = row_on && (span_xr != span_xl);
                div_go_val = DW'(span_zr - span_zl);
                div_go_den = DEN_W'(span_xr - span_xl);
                div_go_job = DJ_ZI;
            end
            default:
            begin
                div_go = 1'b0;
            end
        endcase
    end

    // pixel test and memory ports
    always_comb
    begin
        px_z    = sat16(q_trunc(zacc_reg));
        px_pass = (px_z > depth_q_reg);
        px_idx  = ADDR_W'(ADDR_W'($unsigned(row_y_reg)) * ADDR_W'(SCREEN_WIDTH))
                  + ADDR_W'(px_x_reg);
        rd_idx  = ADDR_W'(ADDR_W'($unsigned(v_reg[0].y)) * ADDR_W'(SCREEN_WIDTH))
                  + ADDR_W'($unsigned(v_reg[0].x));
        mem_raddr  = (state_reg == ST_RD) ? rd_idx : px_idx;
        mem_we     = 1'b0;
        mem_waddr  = px_idx;
        mem_wcolor = fill_reg;
        mem_wdepth = px_z;
        if (state_reg == ST_CLR)
        begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_reg;
            mem_wdepth = DEPTH_FAR;
        end
        else if (state_reg == ST_PX_WR)
        begin
            mem_we = px_pass;
        end
    end

    // color and depth memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[mem_waddr] <= mem_wcolor;
            depth_mem[mem_waddr] <= mem_wdepth;
        end
        color_q_reg <= color_mem[mem_raddr];
        depth_q_reg <= depth_mem[mem_raddr];
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            div_job_reg   <= DJ_MIDX;
            clr_cnt_reg   <= '0;
            wcount_reg    <= '0;
        end
        else
        begin
            // result taken; the done state reloads it itself
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (div_go)
            begin
                div_num_reg <= div_go_val[DW-1] ? DW'(-div_go_val) : DW'(div_go_val);
                div_neg_reg <= div_go_val[DW-1];
                div_den_reg <= div_go_den;
                div_rem_reg <= '0;
                div_quo_reg <= '0;
                div_cnt_reg <= DCNT_W'(DW);
                div_job_reg <= div_go_job;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg       <= cmd_t'(cmd);
                        v_reg[0]      <= '{x: ax, y: ay, z: az};
                        v_reg[1]      <= '{x: bx, y: by_, z: bz};
                        v_reg[2]      <= '{x: cx, y: cy, z: cz};
                        fill_reg      <= fill_color;
                        res_color_reg <= '0;
                        res_depth_reg <= '0;
                        wcount_reg    <= '0;
                        clr_cnt_reg   <= '0;
                        unique case (cmd_t'(cmd))
                            CMD_CLEAR: state_reg <= ST_CLR;
                            CMD_DRAW:  state_reg <= ST_SORT;
                            CMD_READ:  state_reg <= ST_RD;
                            CMD_NONE:  state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(PIX_COUNT - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_RD:
                begin
                    state_reg <= rd_on ? ST_RD_DATA : ST_DONE;
                end
                ST_RD_DATA:
                begin
                    res_color_reg <= color_q_reg;
                    res_depth_reg <= depth_q_reg;
                    state_reg     <= ST_DONE;
                end
                ST_SORT:
                begin
                    v_reg     <= srt;
                    state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    second_reg <= 1'b0;
                    if (v_reg[0].y == v_reg[1].y)
                    begin
                        b1x_reg <= q_of_x(v_reg[0].x); b1z_reg <= q_of_z(v_reg[0].z);
                        b2x_reg <= q_of_x(v_reg[1].x); b2z_reg <= q_of_z(v_reg[1].z);
                        b1y_reg <= v_reg[0].y;
                        top_reg <= v_reg[2];
                        state_reg <= ST_PART;
                    end
                    else if (v_reg[1].y == v_reg[2].y)
                    begin
                        b1x_reg <= q_of_x(v_reg[1].x); b1z_reg <= q_of_z(v_reg[1].z);
                        b2x_reg <= q_of_x(v_reg[2].x); b2z_reg <= q_of_z(v_reg[2].z);
                        b1y_reg <= v_reg[1].y;
                        top_reg <= v_reg[0];
                        state_reg <= ST_PART;
                    end
                    else
                    begin
                        state_reg <= ST_MIDX;
                    end
                end
                ST_MIDX:
                begin
                    mul_reg   <= mul_a * mul_b;
                    state_reg <= ST_MIDX_DIV;
                end
                ST_MIDX_DIV:
                begin
                    state_reg <= ST_DIV;
                end
                ST_MIDZ:
                begin
                    mul_reg   <= mul_a * mul_b;
                    state_reg <= ST_MIDZ_DIV;
                end
                ST_MIDZ_DIV:
                begin
                    state_reg <= ST_DIV;
                end
                ST_PART:
                begin
                    steps_reg   <= part_steps;
                    dir_neg_reg <= part_dy[12];
                    row_i_reg   <= '0;
                    row_y_reg   <= 13'(b1y_reg);
                    rxa_reg     <= b1x_reg;
                    rza_reg     <= b1z_reg;
                    rxb_reg     <= b2x_reg;
                    rzb_reg     <= b2z_reg;
                    dx1_reg     <= '0;
                    dz1_reg     <= '0;
                    dx2_reg     <= '0;
                    dz2_reg     <= '0;
                    state_reg   <= (part_steps != 12'd0) ? ST_DIV : ST_ROW;
                end
                ST_DIV:
                begin
                    if (div_cnt_reg != '0)
                    begin
                        // one quotient bit per cycle
                        div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                        div_num_reg <= div_num_reg << 1;
                        if (div_shift >= {1'b0, div_den_reg})
                        begin
                            div_rem_reg <= DEN_W'(div_shift - {1'b0, div_den_reg});
                            div_quo_reg <= {div_quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            div_rem_reg <= div_shift[DEN_W-1:0];
                            div_quo_reg <= {div_quo_reg[DW-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        unique case (div_job_reg)
                            DJ_MIDX:
                            begin
                                mid_x_reg <= q_of_x(v_reg[0].x) + QW'(div_q);
                                state_reg <= ST_MIDZ;
                            end
                            DJ_MIDZ:
                            begin
                                b1x_reg    <= mid_x_reg;
                                b1z_reg    <= q_of_z(v_reg[0].z) + QW'(div_q);
                                mid_z_reg  <= q_of_z(v_reg[0].z) + QW'(div_q);
                                b2x_reg    <= q_of_x(v_reg[1].x);
                                b2z_reg    <= q_of_z(v_reg[1].z);
                                b1y_reg    <= v_reg[1].y;
                                top_reg    <= v_reg[0];
                                second_reg <= 1'b1;
                                state_reg  <= ST_PART;
                            end
                            DJ_DX1: dx1_reg <= QW'(div_q);
                            DJ_DZ1: dz1_reg <= QW'(div_q);
                            DJ_DX2: dx2_reg <= QW'(div_q);
                            DJ_DZ2:
                            begin
                                dz2_reg   <= QW'(div_q);
                                state_reg <= ST_ROW;
                            end
                            DJ_ZI:
                            begin
                                zi_reg    <= QW'(div_q);
                                state_reg <= ST_SPAN_MUL;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_ROW:
                begin
                    sl_reg  <= span_xl;
                    sr_reg  <= span_xr;
                    szl_reg <= span_zl;
                    zi_reg  <= '0;
                    if (!row_on)
                    begin
                        state_reg <= ST_ROW_NEXT;
                    end
                    else if (span_xr != span_xl)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_SPAN_MUL;
                    end
                end
                ST_SPAN_MUL:
                begin
                    mul_reg   <= mul_a * mul_b;
                    px_x_reg  <= X_W'(span_lo);
                    px_hi_reg <= X_W'(span_hi);
                    state_reg <= (span_lo > span_hi) ? ST_ROW_NEXT : ST_SPAN_INIT;
                end
                ST_SPAN_INIT:
                begin
                    zacc_reg  <= szl_reg + QW'(mul_reg);
                    state_reg <= ST_PX_RD;
                end
                ST_PX_RD:
                begin
                    state_reg <= ST_PX_WR;
                end
                ST_PX_WR:
                begin
                    if (px_pass && (wcount_reg != 16'hffff))
                    begin
                        wcount_reg <= wcount_reg + 16'd1;
                    end
                    if (px_x_reg == px_hi_reg)
                    begin
                        state_reg <= ST_ROW_NEXT;
                    end
                    else
                    begin
                        px_x_reg  <= px_x_reg + X_W'(1);
                        zacc_reg  <= zacc_reg + zi_reg;
                        state_reg <= ST_PX_RD;
                    end
                end
                ST_ROW_NEXT:
                begin
                    if (row_i_reg == steps_reg)
                    begin
                        if (second_reg)
                        begin
                            second_reg <= 1'b0;
                            top_reg    <= v_reg[2];
                            b1x_reg    <= mid_x_reg;
                            b1z_reg    <= mid_z_reg;
                            state_reg  <= ST_PART;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                    else
                    begin
                        row_i_reg <= row_i_reg + 12'd1;
                        row_y_reg <= dir_neg_reg ? row_y_reg - 13'sd1 : row_y_reg + 13'sd1;
                        rxa_reg   <= rxa_reg + dx1_reg;
                        rza_reg   <= rza_reg + dz1_reg;
                        rxb_reg   <= rxb_reg + dx2_reg;
                        rzb_reg   <= rzb_reg + dz2_reg;
                        state_reg <= ST_ROW;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        read_color_reg    <= res_color_reg;
                        read_depth_reg    <= res_depth_reg;
                        written_count_reg <= (cmd_reg == CMD_DRAW) ? wcount_reg : 16'd0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/dtr_checker.sv
// port level checks for the rasterizer, bound to the top level
// depends on depth_tested_triangle_rasterizer ports only

module dtr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [31:0]        read_color,
    input logic signed [15:0] read_depth,
    input logic [15:0]        written_count
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its color and count
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_color) && $stable(written_count))
        else $error("result changed while stalled");

    // an accepted item makes the block busy in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted back to back");

    // a pixel read never reports a write count
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_color != 32'd0 || read_depth != 16'sd0) |-> written_count == 16'd0)
        else $error("read result carries a count");

endmodule

bind depth_tested_triangle_rasterizer dtr_checker u_dtr_checker (.*);

### tb/sv/depth_tested_triangle_rasterizer_tb.sv
// self-checking testbench for the depth tested triangle rasterizer
// depends on dtr_pkg and depth_tested_triangle_rasterizer; results checked against
// a local frame buffer model, directed table first, then random items

module depth_tested_triangle_rasterizer_tb;
    import dtr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      RANDOM_ITEMS = 1800;
    localparam longint  CYCLE_LIMIT  = 40_000_000;
    localparam longint  ONE_Q        = 65536;

    typedef struct {
        logic [1:0]  cmd;
        int          ax, ay, az, bx, by_, bz, cx, cy, cz;
        logic [31:0] col;
        bit          typed;
        logic [31:0] ecol;
        int          edep;
        int          ecnt;
    } item_t;

    typedef struct {
        logic [31:0]        color;
        logic signed [15:0] depth;
        logic [15:0]        count;
    } pixel_result_t;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = '0;
    logic signed [11:0] ax = '0, ay = '0, bx = '0, by_ = '0, cx = '0, cy = '0;
    logic signed [15:0] az = '0, bz = '0, cz = '0;
    logic [31:0]        fill_color = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [31:0]        read_color;
    logic signed [15:0] read_depth;
    logic [15:0]        written_count;

    // frame buffer model and pending results
    logic [31:0]     fb_color [PIX_COUNT];
    shortint         fb_depth [PIX_COUNT];
    int unsigned     pixel_hits;
    pixel_result_t   pending_q[$];
    item_t           dir_rows[$];

    int     errors = 0;
    int     send_pct = 23;
    int     recv_pct = 55;
    int     items_sent = 0;
    logic   hold_out = 1'b0;
    longint cycles = 0;

    depth_tested_triangle_rasterizer u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .ax(ax), .ay(ay), .az(az), .bx(bx), .by_(by_), .bz(bz),
        .cx(cx), .cy(cy), .cz(cz), .fill_color(fill_color),
        .out_valid(out_valid), .out_stall(out_stall), .read_color(read_color),
        .read_depth(read_depth), .written_count(written_count)
    );

    always #4 clk = ~clk;

    // depth tested pixel write
    function automatic void plot_pixel(longint x, longint y, longint z, logic [31:0] c);
        int idx;
        if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
            return;
        idx = int'(y * SCREEN_WIDTH + x);
        if (z > longint'(fb_depth[idx]))
        begin
            fb_color[idx] = c;
            fb_depth[idx] = shortint'(z);
            if (pixel_hits < 65535)
                pixel_hits++;
        end
    endfunction

    // one row between two Q16.16 edge points
    function automatic void fill_span(longint xa, longint za, longint xb, longint zb,
                                      longint y, logic [31:0] c);
        longint xl, xr, zl, zr, t, n, zi, lo, hi, z;
        xl = xa / ONE_Q;
        xr = xb / ONE_Q;
        zl = za;
        zr = zb;
        if (xr < xl)
        begin
            t = xl; xl = xr; xr = t;
            t = zl; zl = zr; zr = t;
        end
        n = xr - xl;
        zi = (n != 0) ? (zr - zl) / n : 0;
        if (y < 0 || y >= SCREEN_HEIGHT)
            return;
        lo = (xl < 0) ? 0 : xl;
        hi = (xr > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : xr;
        for (longint x = lo; x <= hi; x++)
        begin
            z = (zl + (x - xl) * zi) / ONE_Q;
            if (z > 32767) z = 32767;
            if (z < -32768) z = -32768;
            plot_pixel(x, y, z, c);
        end
    endfunction

    // flat sided part: b1 and b2 share a row, both edges run to top
    function automatic void fill_flat(point_t b1, point_t b2, point_t top, logic [31:0] c);
        longint dy, steps, dir, dx1, dz1, dx2, dz2;
        dy = top.y - b1.y;
        steps = (dy < 0) ? -dy : dy;
        dir = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
        dx1 = 0; dz1 = 0; dx2 = 0; dz2 = 0;
        if (steps != 0)
        begin
            dx1 = (top.x - b1.x) / steps;
            dz1 = (top.z - b1.z) / steps;
            dx2 = (top.x - b2.x) / steps;
            dz2 = (top.z - b2.z) / steps;
        end
        for (longint i = 0; i <= steps; i++)
            fill_span(b1.x + i * dx1, b1.z + i * dz1, b2.x + i * dx2, b2.z + i * dz2,
                      b1.y + i * dir, c);
    endfunction

    // sort by y and split at the middle vertex
    function automatic void raster_triangle(point_t p1, point_t p2, point_t p3,
                                            logic [31:0] c);
        point_t t, m;
        longint num, den;
        if (p2.y < p1.y) begin t = p1; p1 = p2; p2 = t; end
        if (p3.y < p1.y) begin t = p1; p1 = p3; p3 = t; end
        if (p3.y < p2.y) begin t = p2; p2 = p3; p3 = t; end
        if (p1.y == p2.y)
            fill_flat(p1, p2, p3, c);
        else if (p2.y == p3.y)
            fill_flat(p2, p3, p1, c);
        else
        begin
            num = p2.y - p1.y;
            den = p3.y - p1.y;
            m.x = p1.x + ((p3.x - p1.x) * num) / den;
            m.y = p2.y;
            m.z = p1.z + ((p3.z - p1.z) * num) / den;
            fill_flat(m, p2, p1, c);
            fill_flat(m, p2, p3, c);
        end
    endfunction

    function automatic point_t mk_point(int x, int y, int z);
        point_t p;
        p.x = longint'(x) * ONE_Q;
        p.y = y;
        p.z = longint'(z) * ONE_Q;
        return p;
    endfunction

    // apply one command to the frame buffer model, return its result
    function automatic pixel_result_t apply_command(item_t r);
        pixel_result_t res;
        res = '{32'd0, 16'sd0, 16'd0};
        case (cmd_t'(r.cmd))
            CMD_CLEAR:
            begin
                for (int i = 0; i < PIX_COUNT; i++)
                begin
                    fb_color[i] = r.col;
                    fb_depth[i] = -32768;
                end
            end
            CMD_DRAW:
            begin
                pixel_hits = 0;
                raster_triangle(mk_point(r.ax, r.ay, r.az), mk_point(r.bx, r.by_, r.bz),
                                mk_point(r.cx, r.cy, r.cz), r.col);
                res.count = pixel_hits[15:0];
            end
            CMD_READ:
            begin
                if (r.ax >= 0 && r.ax < SCREEN_WIDTH && r.ay >= 0 && r.ay < SCREEN_HEIGHT)
                begin
                    res.color = fb_color[r.ay * SCREEN_WIDTH + r.ax];
                    res.depth = fb_depth[r.ay * SCREEN_WIDTH + r.ax];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic item_t mk_item(logic [1:0] c, int x1, int y1, int z1, int x2,
                                      int y2, int z2, int x3, int y3, int z3,
                                      logic [31:0] col);
        item_t r;
        r = '{c, x1, y1, z1, x2, y2, z2, x3, y3, z3, col, 1'b0, 32'd0, 0, 0};
        return r;
    endfunction

    function automatic item_t with_result(item_t r, logic [31:0] c, int d, int n);
        r.typed = 1'b1;
        r.ecol = c;
        r.edep = d;
        r.ecnt = n;
        return r;
    endfunction

    function automatic item_t mk_read(int x, int y);
        return mk_item(CMD_READ, x, y, pick(-32768, 32767), pick(-2048, 2047), 0, 0,
                       pick(-2048, 2047), 0, 0, $urandom);
    endfunction

    // small triangle near the screen, random depths
    function automatic item_t mk_small_draw();
        int x0, y0;
        x0 = pick(-10, 73);
        y0 = pick(-10, 73);
        return mk_item(CMD_DRAW, x0 + pick(-8, 8), y0 + pick(-8, 8), pick(-32768, 32767),
                       x0 + pick(-8, 8), y0 + pick(-8, 8), pick(-32768, 32767),
                       x0 + pick(-8, 8), y0 + pick(-8, 8), pick(-32768, 32767), $urandom);
    endfunction

    function automatic item_t mk_wide_item(logic [1:0] c);
        return mk_item(c, pick(-2048, 2047), pick(-2048, 2047), pick(-32768, 32767),
                       pick(-2048, 2047), pick(-2048, 2047), pick(-32768, 32767),
                       pick(-2048, 2047), pick(-2048, 2047), pick(-32768, 32767),
                       $urandom);
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // offer one item, wait for acceptance, then record what it should return
    task automatic send_item(item_t r);
        pixel_result_t res;
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= r.cmd;
        ax <= r.ax[11:0]; ay <= r.ay[11:0]; az <= r.az[15:0];
        bx <= r.bx[11:0]; by_ <= r.by_[11:0]; bz <= r.bz[15:0];
        cx <= r.cx[11:0]; cy <= r.cy[11:0]; cz <= r.cz[15:0];
        fill_color <= r.col;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = apply_command(r);
        if (r.typed)
            res = '{r.ecol, r.edep[15:0], r.ecnt[15:0]};
        pending_q.push_back(res);
        items_sent++;
    endtask

    // result side: check accepted results and stall at random
    always @(posedge clk)
    begin : take_result
        pixel_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
                report("unexpected result, color", read_color, 0);
            else
            begin
                e = pending_q.pop_front();
                if (read_color !== e.color) report("read_color", read_color, e.color);
                if (read_depth !== e.depth) report("read_depth", read_depth, e.depth);
                if (written_count !== e.count)
                    report("written_count", written_count, e.count);
            end
        end
        out_stall <= hold_out || ($urandom_range(0, 99) < recv_pct);
    end

    // long output hold so the block backs up into its input
    initial
    begin
        wait (items_sent >= 150);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (600) @(posedge clk);
        hold_out <= 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int sel;
        // directed table: reads after clear, off screen reads, no-op command,
        // full screen, zero height, single point, split and flat parts, clipping
        dir_rows.push_back(with_result(mk_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                               32'hffff_ffff), 0, 0, 0));
        dir_rows.push_back(with_result(mk_read(0, 0), 32'hffff_ffff, -32768, 0));
        dir_rows.push_back(with_result(mk_read(63, 63), 32'hffff_ffff, -32768, 0));
        dir_rows.push_back(with_result(mk_read(64, 0), 0, 0, 0));
        dir_rows.push_back(with_result(mk_read(-2048, 2047), 0, 0, 0));
        dir_rows.push_back(with_result(mk_read(2047, -1), 0, 0, 0));
        dir_rows.push_back(with_result(mk_item(CMD_NONE, -1, -1, -1, -1, -1, -1, -1, -1,
                                               -1, 32'hffff_ffff), 0, 0, 0));
        dir_rows.push_back(with_result(mk_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                               32'h0), 0, 0, 0));
        dir_rows.push_back(mk_item(CMD_DRAW, -2048, -2048, 32767, 2047, -2048, 32767,
                                   0, 2047, 32767, 32'ha5a5_a5a5));
        dir_rows.push_back(mk_read(10, 10));
        dir_rows.push_back(mk_item(CMD_DRAW, -2048, -2048, -32768, 2047, -2048, -32768,
                                   0, 2047, -32768, 32'h1234_5678));
        dir_rows.push_back(with_result(mk_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                               32'h5a5a_5a5a), 0, 0, 0));
        dir_rows.push_back(mk_item(CMD_DRAW, 5, 10, 100, 40, 10, 200, 20, 10, 300,
                                   32'h0000_00ff));
        dir_rows.push_back(with_result(mk_item(CMD_DRAW, 3, 3, 0, 3, 3, 0, 3, 3, 0,
                                               32'h00ff_0000), 0, 0, 1));
        dir_rows.push_back(mk_item(CMD_DRAW, 10, 2, -1000, 50, 30, 5000, 20, 60, 20000,
                                   32'h0f0f_0f0f));
        dir_rows.push_back(mk_item(CMD_DRAW, 0, 0, 300, 30, 0, 400, 15, 40, 500,
                                   32'hf0f0_f0f0));
        dir_rows.push_back(mk_item(CMD_DRAW, 15, 0, 600, 0, 40, 700, 30, 40, 800,
                                   32'h8000_0001));
        dir_rows.push_back(mk_item(CMD_DRAW, 50, 5, 9000, 5, 5, -9000, 30, 50, 0,
                                   32'h7fff_fffe));
        dir_rows.push_back(mk_item(CMD_DRAW, -20, -20, 32767, 80, 10, -32768, 30, 90, 0,
                                   32'hdead_0001));
        dir_rows.push_back(mk_read(20, 20));
        dir_rows.push_back(mk_read(3, 3));
        dir_rows.push_back(mk_item(CMD_DRAW, 10, 2, -2000, 50, 30, 4000, 20, 60, 19000,
                                   32'h0bad_0bad));
        dir_rows.push_back(mk_item(CMD_DRAW, 0, 0, -32768, 63, 0, 32767, 0, 63, 32767,
                                   32'hcafe_0002));
        dir_rows.push_back(mk_read(0, 0));
        dir_rows.push_back(mk_read(30, 20));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // random part in three idling phases
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_pct = 55;
                recv_pct = 23;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            sel = pick(0, 99);
            if (sel < 2)
                send_item(mk_item(CMD_CLEAR, pick(-2048, 2047), pick(-2048, 2047),
                                  pick(-32768, 32767), 0, 0, 0, 0, 0, 0, $urandom));
            else if (sel < 40)
                send_item(mk_small_draw());
            else if (sel < 41)
                send_item(mk_wide_item(CMD_DRAW));
            else if (sel < 85)
                send_item(mk_read(pick(-3, 66), pick(-3, 66)));
            else if (sel < 91)
                send_item(mk_read(pick(-2048, 2047), pick(-2048, 2047)));
            else
                send_item(mk_wide_item(CMD_NONE));
        end

        @(posedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hw/rtl/dtr_pkg.sv
hw/rtl/depth_tested_triangle_rasterizer.sv
hw/rtl/dtr_checker.sv
tb/sv/depth_tested_triangle_rasterizer_tb.sv
